>>> sv/swm_pkg.sv
// Package for the sliding window median unit: default sizes, cell operation codes
// and the sequencer state type.
// Used by swm_cell, swm_row and sliding_window_median_unit.
package swm_pkg;

	localparam int WINDOW_MAX_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int CFG_WIDTH        = 7;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE
	} swm_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_REMOVE
	} swm_state_t;

endpackage

>>> sv/swm_cell.sv
// One cell of the sorted row: holds a single sample and trades it with its neighbors.
// Depends on swm_pkg for the operation codes.
module swm_cell #(
	parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                    clk,
	input  swm_pkg::swm_op_t        op,
	input  logic [SAMPLE_WIDTH-1:0] key,
	input  logic                    live,
	input  logic [SAMPLE_WIDTH-1:0] left_val,
	input  logic                    left_gt,
	input  logic [SAMPLE_WIDTH-1:0] right_val,
	output logic [SAMPLE_WIDTH-1:0] val,
	output logic                    gt
);

	logic [SAMPLE_WIDTH-1:0] val_q;
	logic                    claim;
	logic                    ge;

	// A cell claims the new sample if it is empty or holds a larger value.
	assign gt    = live && (val_q > key);
	assign claim = !live || (val_q > key);
	assign ge    = (val_q >= key);
	assign val   = val_q;

	always_ff @(posedge clk) begin
		case (op)
			swm_pkg::OP_INSERT: begin
				if (left_gt) begin
					val_q <= left_val;
				end else if (claim) begin
					val_q <= key;
				end
			end
			swm_pkg::OP_REMOVE: begin
				// Every cell from the leaving value upward takes its right neighbor.
				if (ge) begin
					val_q <= right_val;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/swm_row.sv
// Chain of sorted cells with the median tap.
// Depends on swm_pkg and swm_cell.
module swm_row #(
	parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
	localparam int PTR_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
	input  logic                    clk,
	input  swm_pkg::swm_op_t        op,
	input  logic [SAMPLE_WIDTH-1:0] key,
	input  logic [WINDOW_MAX-1:0]   live,
	input  logic [PTR_W-1:0]        mid_idx,
	output logic [SAMPLE_WIDTH-1:0] mid_val
);

	logic [SAMPLE_WIDTH-1:0] vals [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]   gts;

	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
		logic [SAMPLE_WIDTH-1:0] left_val;
		logic [SAMPLE_WIDTH-1:0] right_val;
		logic                    left_gt;

		if (g == 0) begin : g_first
			assign left_val = vals[g];
			assign left_gt  = 1'b0;
		end else begin : g_inner
			assign left_val = vals[g-1];
			assign left_gt  = gts[g-1];
		end

		if (g == WINDOW_MAX - 1) begin : g_last
			assign right_val = vals[g];
		end else begin : g_body
			assign right_val = vals[g+1];
		end

		swm_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_cell (
			.clk      (clk),
			.op       (op),
			.key      (key),
			.live     (live[g]),
			.left_val (left_val),
			.left_gt  (left_gt),
			.right_val(right_val),
			.val      (vals[g]),
			.gt       (gts[g])
		);
	end

	assign mid_val = vals[mid_idx];

endmodule

>>> sv/sliding_window_median_unit.sv
// Top level of the running median filter: sequencer, arrival ring and sorted cell row.
// Depends on swm_pkg and swm_row.
//
//   channel   signals                                   direction
//   input     in_valid, in_stall, sample, restart       word in
//   output    out_valid, out_stall, median              word out
//   config    cfg_wr_en, cfg_wr_data                    window size write
//
// A word that does not complete the window only goes through the insert in the cell row.
// A word that completes the window is inserted through the cell row, then the oldest sample
// is removed, its value taken from the arrival ring read port.
// The removal cycle waits while the output register holds an untaken result.
// Reset empties the window and sets the window size to one; the sample stores are not cleared.
// in_stall is high only during the removal cycle.
module sliding_window_median_unit #(
	parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [SAMPLE_WIDTH-1:0]        sample,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [SAMPLE_WIDTH-1:0]        median,
	input  logic                           cfg_wr_en,
	input  logic [swm_pkg::CFG_WIDTH-1:0]  cfg_wr_data
);

	localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int FILL_W = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W  = (FILL_W > swm_pkg::CFG_WIDTH) ? FILL_W : swm_pkg::CFG_WIDTH;
	localparam int SUM_W  = PTR_W + 1;

	swm_pkg::swm_state_t state_q, state_d;
	swm_pkg::swm_op_t    op;

	logic [FILL_W-1:0]       fill_q;
	logic [PTR_W-1:0]        oldest_q;
	logic [FILL_W-1:0]       k_q;
	logic [PTR_W-1:0]        mid_q;
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] median_q;
	logic [SAMPLE_WIDTH-1:0] x_q;
	logic [SAMPLE_WIDTH-1:0] ring_mem [WINDOW_MAX];

	logic [SAMPLE_WIDTH-1:0] key;
	logic [SAMPLE_WIDTH-1:0] mid_val;
	logic [WINDOW_MAX-1:0]   live;
	logic                    acc;
	logic                    load_out;
	logic                    fresh;
	logic [FILL_W-1:0]       f0;
	logic [PTR_W-1:0]        ptr0;
	logic [SUM_W-1:0]        slot_sum;
	logic [PTR_W-1:0]        slot;
	logic                    full_now;
	logic [PTR_W-1:0]        ptr_inc;
	logic [CMP_W-1:0]        ws_wide;
	logic [FILL_W-1:0]       new_k;
	logic [FILL_W-1:0]       new_km1;
	logic [PTR_W-1:0]        new_mid;

	// Effective window size and median index of a written size.
	always_comb begin
		ws_wide = CMP_W'(cfg_wr_data);
		if (ws_wide == '0) begin
			new_k = FILL_W'(1);
		end else if (ws_wide > CMP_W'(WINDOW_MAX)) begin
			new_k = FILL_W'(WINDOW_MAX);
		end else begin
			new_k = FILL_W'(ws_wide);
		end
		new_km1 = new_k - FILL_W'(1);
		new_mid = PTR_W'(new_km1 >> 1);
	end

	// A restart or a stale full window starts the sequence afresh.
	assign fresh    = restart || (fill_q >= k_q);
	assign f0       = fresh ? '0 : fill_q;
	assign ptr0     = fresh ? '0 : oldest_q;
	assign slot_sum = SUM_W'(ptr0) + SUM_W'(f0);
	assign slot     = (slot_sum >= SUM_W'(WINDOW_MAX)) ?
		PTR_W'(slot_sum - SUM_W'(WINDOW_MAX)) : PTR_W'(slot_sum);
	assign full_now = (FILL_W'(f0 + FILL_W'(1)) == k_q);
	assign ptr_inc  = (oldest_q == PTR_W'(WINDOW_MAX - 1)) ? '0 : oldest_q + PTR_W'(1);

	always_comb begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			live[i] = (FILL_W'(i) < f0);
		end
	end

	assign in_stall = (state_q != swm_pkg::ST_IDLE);
	assign acc      = in_valid && !in_stall;

	always_comb begin
		state_d  = state_q;
		op       = swm_pkg::OP_HOLD;
		key      = sample;
		load_out = 1'b0;
		case (state_q)
			swm_pkg::ST_IDLE: begin
				if (in_valid) begin
					op = swm_pkg::OP_INSERT;
					if (full_now) begin
						state_d = swm_pkg::ST_REMOVE;
					end
				end
			end
			swm_pkg::ST_REMOVE: begin
				if (!out_valid_q || !out_stall) begin
					op       = swm_pkg::OP_REMOVE;
					key      = x_q;
					load_out = 1'b1;
					state_d  = swm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swm_pkg::ST_IDLE;
			fill_q      <= '0;
			oldest_q    <= '0;
			k_q         <= FILL_W'(1);
			mid_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				k_q      <= new_k;
				mid_q    <= new_mid;
				fill_q   <= '0;
				oldest_q <= '0;
			end else if (acc) begin
				oldest_q <= ptr0;
				fill_q   <= full_now ? f0 : FILL_W'(f0 + FILL_W'(1));
			end else if (load_out) begin
				oldest_q <= ptr_inc;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ring_mem[slot] <= sample;
		end
	end

	// The oldest sample is the new one itself when the window was empty.
	always_ff @(posedge clk) begin
		if (acc) begin
			x_q <= (f0 == '0) ? sample : ring_mem[ptr0];
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			median_q <= mid_val;
		end
	end

	swm_row #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_row (
		.clk    (clk),
		.op     (op),
		.key    (key),
		.live   (live),
		.mid_idx(mid_q),
		.mid_val(mid_val)
	);

	assign out_valid = out_valid_q;
	assign median    = median_q;

	a_fill_below_size: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < k_q)
		else $error("window fill reached the window size");

	a_result_from_remove: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == swm_pkg::ST_REMOVE))
		else $error("result appeared without a removal cycle");

	a_remove_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swm_pkg::ST_REMOVE) && (!out_valid_q || !out_stall)
		|=> out_valid && (state_q == swm_pkg::ST_IDLE))
		else $error("removal cycle did not deliver a result");

endmodule
